[sv/canny_nonmax_suppression_macros.svh]
`ifndef CANNY_NONMAX_SUPPRESSION_MACROS_SVH
`define CANNY_NONMAX_SUPPRESSION_MACROS_SVH
// assertion helpers
`define CNMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CNMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/cnms_pkg.sv]
package cnms_pkg;
   localparam int MagW = 16;
   localparam int GradW = 11;
   localparam int RowW = 12;
   localparam int ColW = 11;
   localparam int FwW = 12;
   localparam int FhW = 13;
   localparam int MaxHeight = 4096;
   localparam logic [0:0] CSR_FRAME_WIDTH = 1'b0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_CALC  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic read;
      logic calc;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;
endpackage

[sv/cnms_ctrl.sv]
`include "canny_nonmax_suppression_macros.svh"
module cnms_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  cnms_pkg::status_type status,
   output cnms_pkg::cmd_type cmd
);
   import cnms_pkg::*;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CNMS_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `CNMS_ASSERT_NEXT(a_acc, clock, reset, req_tvalid && req_tready, state_ff == ST_READ,
      "accept did not start read")
   `CNMS_ASSERT_NEXT(a_rd, clock, reset, cmd.read, cmd.calc, "read not followed by calc")
endmodule

[sv/cnms_datapath.sv]
module cnms_datapath #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAG_FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wen,
   input  logic [0:0] csr_index,
   input  logic [cnms_pkg::FhW-1:0] csr_wdata,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [39:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic rsp_tlast,
   input  cnms_pkg::cmd_type cmd,
   output cnms_pkg::status_type status
);
   import cnms_pkg::*;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [FwW-1:0] fw_ff;
   logic [FhW-1:0] fh_ff;
   logic [CW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic [CW-1:0] fill_ff;
   logic [MagW-1:0] mag_ff;
   logic [GradW-1:0] gx_ff, gy_ff, hgx_ff, hgy_ff;
   logic [MagW-1:0] mp_mem [MAX_WIDTH];
   logic [MagW-1:0] mo_mem [MAX_WIDTH];
   logic [GradW-1:0] gxm [MAX_WIDTH];
   logic [GradW-1:0] gym [MAX_WIDTH];
   logic [MagW-1:0] rp_ff, ro_ff;
   logic [GradW-1:0] rgx_ff, rgy_ff;
   logic rv_ff;
   logic [MagW-1:0] win_ff [9];
   logic rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic rsp_last_ff;
   logic [CW-1:0] w_eff, c_eff, c_next;
   logic [FhW-1:0] h_eff;
   logic [RowW-1:0] r_eff;
   logic [AW-1:0] addr;
   logic [MagW-1:0] rp, ro;
   logic [GradW-1:0] rgx, rgy;

   always_comb begin
      w_eff = (fw_ff < FwW'(3)) ? CW'(3) : ((32'(fw_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(fw_ff));
      h_eff = (fh_ff < FhW'(3)) ? FhW'(3) : ((32'(fh_ff) > MaxHeight) ? FhW'(MaxHeight) : fh_ff);
      c_eff = (col_ff >= w_eff) ? '0 : col_ff;
      r_eff = (FhW'(row_ff) >= h_eff) ? '0 : row_ff;
      addr = c_eff[AW-1:0];
      rp = rv_ff ? rp_ff : '0;
      ro = rv_ff ? ro_ff : '0;
      rgx = rv_ff ? rgx_ff : '0;
      rgy = rv_ff ? rgy_ff : '0;
      c_next = c_eff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rp_ff <= mp_mem[addr];
         ro_ff <= mo_mem[addr];
         rgx_ff <= gxm[addr];
         rgy_ff <= gym[addr];
      end
      if (cmd.calc) begin
         mp_mem[addr] <= mag_ff;
         mo_mem[addr] <= rp;
         gxm[addr] <= gx_ff;
         gym[addr] <= gy_ff;
      end
   end

   // centre data and window
   logic [MagW-1:0] w [9];
   logic signed [GradW-1:0] sgx, sgy;
   logic [GradW-1:0] ax, ay, s, l;
   logic same, xdom;
   logic [MagW-1:0] pa, pb, na, nb;
   logic [MagW+GradW:0] lhs, rp_sum, rn_sum;
   logic keep;
   logic [MagW-1:0] ipw;
   logic [7:0] val;
   logic [RowW-1:0] orow;
   logic [ColW-1:0] ocol;
   logic interior, done;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         w[k*3] = win_ff[k*3+1];
         w[k*3+1] = win_ff[k*3+2];
      end
      w[2] = ro;
      w[5] = rp;
      w[8] = mag_ff;
      sgx = signed'(hgx_ff);
      sgy = signed'(hgy_ff);
      ax = sgx[GradW-1] ? GradW'(-sgx) : hgx_ff;
      ay = sgy[GradW-1] ? GradW'(-sgy) : hgy_ff;
      same = (sgx > 0 && sgy > 0) || (sgx < 0 && sgy < 0);
      xdom = ax >= ay;
      s = xdom ? ay : ax;
      l = xdom ? ax : ay;
      pa = xdom ? w[5] : w[7];
      na = xdom ? w[3] : w[1];
      pb = same ? w[8] : (xdom ? w[2] : w[6]);
      nb = same ? w[0] : (xdom ? w[6] : w[2]);
      lhs = (MagW+GradW+1)'(w[4]) * (MagW+GradW+1)'(l);
      rp_sum = (MagW+GradW+1)'(GradW'(l - s)) * (MagW+GradW+1)'(pa)
             + (MagW+GradW+1)'(s) * (MagW+GradW+1)'(pb);
      rn_sum = (MagW+GradW+1)'(GradW'(l - s)) * (MagW+GradW+1)'(na)
             + (MagW+GradW+1)'(s) * (MagW+GradW+1)'(nb);
      keep = (w[4] != '0) && (l != '0) && (lhs >= rp_sum) && (lhs >= rn_sum);
      ipw = w[4] >> MAG_FRAC_BITS;
      val = (ipw > MagW'(255)) ? 8'd255 : ipw[7:0];
      interior = 1'b0;
      if (r_eff == '0) begin
         orow = '0;
         ocol = ColW'(c_eff);
      end else if (r_eff == RowW'(1)) begin
         orow = RowW'(h_eff - FhW'(1));
         ocol = ColW'(c_eff);
      end else if (c_eff == '0) begin
         orow = r_eff - RowW'(1);
         ocol = '0;
      end else if (c_eff == CW'(1)) begin
         orow = r_eff - RowW'(1);
         ocol = ColW'(w_eff - CW'(1));
      end else begin
         orow = r_eff - RowW'(1);
         ocol = ColW'(c_eff - CW'(1));
         interior = 1'b1;
      end
      done = (FhW'(r_eff) == h_eff - FhW'(1)) && (c_eff == w_eff - CW'(1));
   end

   logic [31:0] res_ff;
   logic res_last_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mag_ff <= req_tdata[MagW-1:0];
         gx_ff <= req_tdata[MagW +: GradW];
         gy_ff <= req_tdata[MagW+GradW +: GradW];
      end
      if (cmd.calc) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= w[k];
         hgx_ff <= rgx;
         hgy_ff <= rgy;
         res_ff <= {1'b0, ocol, orow, interior && keep ? val : 8'd0};
         res_last_ff <= done;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= res_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FwW'(640);
         fh_ff <= FhW'(480);
         col_ff <= '0;
         row_ff <= '0;
         fill_ff <= '0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_FRAME_WIDTH) fw_ff <= csr_wdata[FwW-1:0];
            else fh_ff <= csr_wdata;
            col_ff <= '0;
            row_ff <= '0;
         end
         if (cmd.read) rv_ff <= c_eff < fill_ff;
         if (cmd.calc) begin
            if (c_eff == fill_ff) fill_ff <= fill_ff + CW'(1);
            if (c_next >= w_eff) begin
               col_ff <= '0;
               row_ff <= (FhW'(r_eff) + FhW'(1) >= h_eff) ? '0 : r_eff + RowW'(1);
            end else begin
               col_ff <= c_next;
               row_ff <= r_eff;
            end
         end
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;
endmodule

[sv/canny_nonmax_suppression.sv]
// Canny non-maximum suppression, interpolated along the gradient.
// req_ channel: one pixel per item, raster order (magnitude, grad_x, grad_y).
// rsp_ channel: exactly one result per accepted pixel (edge_value, out_row,
//   out_col); rsp_tlast marks the last result of the frame.
// csr_ port: index 0 frame_width, index 1 frame_height; a write restarts
//   the frame counters, line stores keep their content.
// Each item passes through accept, line store read, window/compare and output
//   load steps. The controller runs these steps one after another for each item.
// rsp_tvalid is registered and rises once the output load step is taken.
// Reset: registers back to 640x480, counters to zero, output empty.
// A stalled receiver holds the output register; the next item is then
//   accepted but waits in the output load step until the register frees.
// Line stores read as zero until written, tracked by a fill count of the
//   columns written since reset.
module canny_nonmax_suppression #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAG_FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wen,
   input  logic [0:0] csr_index,
   input  logic [12:0] csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [39:0] req_tdata,   // magnitude[15:0], grad_x[26:16], grad_y[37:27]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // edge_value[7:0], out_row[19:8], out_col[30:20]
   output logic rsp_tlast
);
   import cnms_pkg::*;
   cmd_type cmd;
   status_type status;

   cnms_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   cnms_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAG_FRAC_BITS(MAG_FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .cmd(cmd), .status(status)
   );
endmodule
